/* hdl/idkh_pkg.sv */
// shared types and codes for the indexed min-heap decrease-key unit
// no dependencies; imported by the interfaces, controller, datapath and top level
`default_nettype none

package idkh_pkg;

  // function codes on the input channel
  localparam logic [1:0] FN_INSERT = 2'd0;
  localparam logic [1:0] FN_DELMIN = 2'd1;
  localparam logic [1:0] FN_CLEAR  = 2'd2;

  // result status codes
  localparam logic [2:0] ST_INSERTED  = 3'd0;
  localparam logic [2:0] ST_DECREASED = 3'd1;
  localparam logic [2:0] ST_IGNORED   = 3'd2;
  localparam logic [2:0] ST_REMOVED   = 3'd3;
  localparam logic [2:0] ST_EMPTY     = 3'd4;

  // field widths fixed by the channels
  localparam int unsigned FUNC_W   = 2;
  localparam int unsigned KEY_W    = 32;
  localparam int unsigned ITEM_W   = 10;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned COUNT_W  = 11;

  // controller states
  typedef enum logic [3:0] {
    S_CLR,
    S_IDLE,
    S_INS_POS,
    S_INS_CHK,
    S_DEC_CHK,
    S_SU_RD,
    S_SU_CMP,
    S_DM_START,
    S_DM_TOP,
    S_DM_LAST,
    S_SD_RD,
    S_SD_RD2,
    S_SD_CMP,
    S_DONE
  } state_t;

  // datapath operations
  typedef enum logic [3:0] {
    OP_CLR,
    OP_IDLE,
    OP_INS_POS,
    OP_INS_CHK,
    OP_DEC_CHK,
    OP_SU_RD,
    OP_SU_CMP,
    OP_DM_START,
    OP_DM_TOP,
    OP_DM_LAST,
    OP_SD_RD,
    OP_SD_RD2,
    OP_SD_CMP,
    OP_DONE
  } op_t;

  // controller to datapath command
  typedef struct packed {
    op_t  op;
    logic accept;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic in_range;
    logic pos_removed;
    logic pos_valid;
    logic heap_full;
    logic key_less;
    logic cur_root;
    logic up_swap;
    logic size_zero;
    logic size_one;
    logic child_out;
    logic down_swap;
    logic clr_last;
    logic out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

/* hdl/idkh_in_if.sv */
// input channel interface: valid/ready handshake with the request payload
// depends on idkh_pkg for field widths
`default_nettype none

interface idkh_in_if
  import idkh_pkg::*;
;
  logic                valid;
  logic                ready;
  logic [FUNC_W-1:0]   func;
  logic [KEY_W-1:0]    key;
  logic [ITEM_W-1:0]   item_id;

  modport source (output valid, output func, output key, output item_id, input ready);
  modport sink   (input valid, input func, input key, input item_id, output ready);
endinterface

`default_nettype wire

/* hdl/idkh_out_if.sv */
// result channel interface: valid/ready handshake with the result payload
// depends on idkh_pkg for field widths
`default_nettype none

interface idkh_out_if
  import idkh_pkg::*;
;
  logic                valid;
  logic                ready;
  logic [KEY_W-1:0]    min_key;
  logic [ITEM_W-1:0]   min_item;
  logic [STATUS_W-1:0] status;
  logic [COUNT_W-1:0]  count;

  modport source (output valid, output min_key, output min_item, output status,
                  output count, input ready);
  modport sink   (input valid, input min_key, input min_item, input status,
                  input count, output ready);
endinterface

`default_nettype wire

/* hdl/idkh_ctrl.sv */
// controller state machine: sequences insert, decrease, delete-min and clear
// depends on idkh_pkg; drives the datapath through cmd_t, reads dp_stat_t
`default_nettype none

module idkh_ctrl
  import idkh_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic [FUNC_W-1:0] in_func,
  output logic                   in_ready,
  input  wire dp_stat_t          stat,
  output cmd_t                   cmd
);

  state_t state_r, state_nxt;
  logic   reply_r;
  logic   accept;

  assign accept = (state_r == S_IDLE) && in_valid;

  // state register; reset starts a clearing pass with no result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      reply_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (accept) begin
        reply_r <= (in_func == FN_CLEAR);
      end
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLR: begin
        if (stat.clr_last) state_nxt = reply_r ? S_DONE : S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          unique case (in_func)
            FN_INSERT: state_nxt = S_INS_POS;
            FN_DELMIN: state_nxt = S_DM_START;
            FN_CLEAR:  state_nxt = S_CLR;
            default:   state_nxt = S_DONE;
          endcase
        end
      end
      S_INS_POS: state_nxt = S_INS_CHK;
      S_INS_CHK: begin
        if (!stat.in_range || stat.pos_removed) state_nxt = S_DONE;
        else if (stat.pos_valid)                state_nxt = S_DEC_CHK;
        else if (stat.heap_full)                state_nxt = S_DONE;
        else                                    state_nxt = S_SU_RD;
      end
      S_DEC_CHK:  state_nxt = stat.key_less ? S_SU_RD : S_DONE;
      S_SU_RD:    state_nxt = stat.cur_root ? S_DONE : S_SU_CMP;
      S_SU_CMP:   state_nxt = stat.up_swap ? S_SU_RD : S_DONE;
      S_DM_START: state_nxt = stat.size_zero ? S_DONE : S_DM_TOP;
      S_DM_TOP:   state_nxt = S_DM_LAST;
      S_DM_LAST:  state_nxt = stat.size_one ? S_DONE : S_SD_RD;
      S_SD_RD:    state_nxt = stat.child_out ? S_DONE : S_SD_RD2;
      S_SD_RD2:   state_nxt = S_SD_CMP;
      S_SD_CMP:   state_nxt = stat.down_swap ? S_SD_RD : S_DONE;
      S_DONE: begin
        if (stat.out_free) state_nxt = S_IDLE;
      end
      default:    state_nxt = S_CLR;
    endcase
  end

  // outputs
  always_comb begin
    in_ready   = (state_r == S_IDLE);
    cmd.accept = accept;
    unique case (state_r)
      S_CLR:      cmd.op = OP_CLR;
      S_IDLE:     cmd.op = OP_IDLE;
      S_INS_POS:  cmd.op = OP_INS_POS;
      S_INS_CHK:  cmd.op = OP_INS_CHK;
      S_DEC_CHK:  cmd.op = OP_DEC_CHK;
      S_SU_RD:    cmd.op = OP_SU_RD;
      S_SU_CMP:   cmd.op = OP_SU_CMP;
      S_DM_START: cmd.op = OP_DM_START;
      S_DM_TOP:   cmd.op = OP_DM_TOP;
      S_DM_LAST:  cmd.op = OP_DM_LAST;
      S_SD_RD:    cmd.op = OP_SD_RD;
      S_SD_RD2:   cmd.op = OP_SD_RD2;
      S_SD_CMP:   cmd.op = OP_SD_CMP;
      S_DONE:     cmd.op = OP_DONE;
      default:    cmd.op = OP_IDLE;
    endcase
  end

endmodule

`default_nettype wire

/* hdl/idkh_dp.sv */
// datapath: heap memories, position table, sift registers and result register
// depends on idkh_pkg; commanded by idkh_ctrl
`default_nettype none

module idkh_dp
  import idkh_pkg::*;
#(
  parameter int unsigned NUM_ITEMS = 1024,
  parameter int unsigned KEY_BITS  = 32,
  parameter int unsigned IW        = 10,
  parameter int unsigned SW        = 11
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire cmd_t                cmd,
  output dp_stat_t                 stat,
  input  wire logic [KEY_W-1:0]    in_key,
  input  wire logic [ITEM_W-1:0]   in_item_id,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [KEY_W-1:0]         out_min_key,
  output logic [ITEM_W-1:0]        out_min_item,
  output logic [STATUS_W-1:0]      out_status,
  output logic [COUNT_W-1:0]       out_count
);

  localparam int unsigned PW = SW + 2;  // removed, valid, index

  // storage
  logic [KEY_BITS-1:0] heap_key_mem  [0:NUM_ITEMS];
  logic [IW-1:0]       heap_item_mem [0:NUM_ITEMS];
  logic [PW-1:0]       pos_mem       [0:NUM_ITEMS-1];

  // memory ports
  logic                hrd_en, hwr_en, prd_en, pwr_en;
  logic [SW-1:0]       hrd_addr, hwr_addr;
  logic [KEY_BITS-1:0] hwr_key, hq_key;
  logic [IW-1:0]       hwr_item, hq_item, prd_addr, pwr_addr;
  logic [PW-1:0]       pwr_data, pq;

  // working registers
  logic [KEY_BITS-1:0] key_r, ck_r, lk_r, min_key_r;
  logic [IW-1:0]       id_r, ci_r, li_r, min_item_r, clr_cnt_r;
  logic [SW-1:0]       size_r, cur_r;
  logic                in_range_r, rin_r;
  logic [STATUS_W-1:0] status_r;

  // result register
  logic                out_valid_r;
  logic [KEY_W-1:0]    out_min_key_r;
  logic [ITEM_W-1:0]   out_min_item_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [COUNT_W-1:0]  out_count_r;

  // derived values
  logic [SW:0]         child_l, child_r;
  logic                take_right;
  logic [KEY_BITS-1:0] ch_key;
  logic [IW-1:0]       ch_item;
  logic [SW-1:0]       ch_idx;
  logic [SW-1:0]       pq_idx;

  assign pq_idx     = pq[SW-1:0];
  assign child_l    = {cur_r, 1'b0};
  assign child_r    = {cur_r, 1'b1};
  assign take_right = rin_r && (hq_key < lk_r);
  assign ch_key     = take_right ? hq_key  : lk_r;
  assign ch_item    = take_right ? hq_item : li_r;
  assign ch_idx     = take_right ? child_r[SW-1:0] : child_l[SW-1:0];

  // status toward the controller
  always_comb begin
    stat.in_range    = in_range_r;
    stat.pos_removed = pq[SW+1];
    stat.pos_valid   = pq[SW];
    stat.heap_full   = (size_r == SW'(NUM_ITEMS));
    stat.key_less    = (key_r < hq_key);
    stat.cur_root    = (cur_r == SW'(1));
    stat.up_swap     = (ck_r < hq_key);
    stat.size_zero   = (size_r == '0);
    stat.size_one    = (size_r == SW'(1));
    stat.child_out   = (child_l > {1'b0, size_r});
    stat.down_swap   = (ck_r > ch_key);
    stat.clr_last    = (clr_cnt_r == IW'(NUM_ITEMS - 1));
    stat.out_free    = !out_valid_r || out_ready;
  end

  // memory port control per operation
  always_comb begin
    hrd_en   = 1'b0;
    hrd_addr = cur_r;
    hwr_en   = 1'b0;
    hwr_addr = cur_r;
    hwr_key  = ck_r;
    hwr_item = ci_r;
    prd_en   = 1'b0;
    prd_addr = id_r;
    pwr_en   = 1'b0;
    pwr_addr = ci_r;
    pwr_data = {2'b01, cur_r};
    case (cmd.op)
      OP_CLR: begin
        pwr_en   = 1'b1;
        pwr_addr = clr_cnt_r;
        pwr_data = '0;
      end
      OP_INS_POS: prd_en = 1'b1;
      OP_INS_CHK: begin
        hrd_en   = 1'b1;
        hrd_addr = pq_idx;
      end
      OP_SU_RD: begin
        if (cur_r == SW'(1)) begin
          hwr_en = 1'b1;
          pwr_en = 1'b1;
        end else begin
          hrd_en   = 1'b1;
          hrd_addr = cur_r >> 1;
        end
      end
      OP_SU_CMP: begin
        hwr_en = 1'b1;
        pwr_en = 1'b1;
        if (ck_r < hq_key) begin
          hwr_key  = hq_key;
          hwr_item = hq_item;
          pwr_addr = hq_item;
        end
      end
      OP_DM_START: begin
        hrd_en   = 1'b1;
        hrd_addr = SW'(1);
      end
      OP_DM_TOP: begin
        hrd_en   = 1'b1;
        hrd_addr = size_r;
        pwr_en   = 1'b1;
        pwr_addr = hq_item;
        pwr_data = {2'b10, {SW{1'b0}}};
      end
      OP_SD_RD: begin
        if (child_l > {1'b0, size_r}) begin
          hwr_en = 1'b1;
          pwr_en = 1'b1;
        end else begin
          hrd_en   = 1'b1;
          hrd_addr = child_l[SW-1:0];
        end
      end
      OP_SD_RD2: begin
        hrd_en   = 1'b1;
        hrd_addr = child_r[SW-1:0];
      end
      OP_SD_CMP: begin
        hwr_en = 1'b1;
        pwr_en = 1'b1;
        if (ck_r > ch_key) begin
          hwr_key  = ch_key;
          hwr_item = ch_item;
          pwr_addr = ch_item;
        end
      end
      default: ;
    endcase
  end

  // heap memory, registered read
  always_ff @(posedge clk) begin
    if (hwr_en) begin
      heap_key_mem[hwr_addr]  <= hwr_key;
      heap_item_mem[hwr_addr] <= hwr_item;
    end
    if (hrd_en) begin
      hq_key  <= heap_key_mem[hrd_addr];
      hq_item <= heap_item_mem[hrd_addr];
    end
  end

  // position table, registered read
  always_ff @(posedge clk) begin
    if (pwr_en) pos_mem[pwr_addr] <= pwr_data;
    if (prd_en) pq <= pos_mem[prd_addr];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r    <= '0;
      clr_cnt_r <= '0;
    end else begin
      case (cmd.op)
        OP_CLR: begin
          size_r    <= '0;
          clr_cnt_r <= clr_cnt_r + IW'(1);
        end
        OP_IDLE: begin
          if (cmd.accept) clr_cnt_r <= '0;
        end
        OP_INS_CHK: begin
          if (in_range_r && !pq[SW+1] && !pq[SW] && (size_r != SW'(NUM_ITEMS))) begin
            size_r <= size_r + SW'(1);
          end
        end
        OP_DM_LAST: size_r <= size_r - SW'(1);
        default: ;
      endcase
    end
  end

  // payload registers of the operation in progress
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_CLR: status_r <= ST_EMPTY;
      OP_IDLE: begin
        if (cmd.accept) begin
          key_r      <= KEY_BITS'(in_key);
          id_r       <= IW'(in_item_id);
          in_range_r <= (32'(in_item_id) < 32'(NUM_ITEMS));
          status_r   <= ST_IGNORED;
          min_key_r  <= '0;
          min_item_r <= '0;
        end
      end
      OP_INS_CHK: begin
        ck_r <= key_r;
        ci_r <= id_r;
        if (pq[SW]) begin
          cur_r <= pq_idx;
        end else begin
          cur_r <= size_r + SW'(1);
          if (in_range_r && !pq[SW+1] && (size_r != SW'(NUM_ITEMS))) begin
            status_r <= ST_INSERTED;
          end
        end
      end
      OP_DEC_CHK: begin
        if (key_r < hq_key) status_r <= ST_DECREASED;
      end
      OP_SU_CMP: begin
        if (ck_r < hq_key) cur_r <= cur_r >> 1;
      end
      OP_DM_START: begin
        if (size_r == '0) status_r <= ST_EMPTY;
      end
      OP_DM_TOP: begin
        min_key_r  <= hq_key;
        min_item_r <= hq_item;
        status_r   <= ST_REMOVED;
      end
      OP_DM_LAST: begin
        ck_r  <= hq_key;
        ci_r  <= hq_item;
        cur_r <= SW'(1);
      end
      OP_SD_RD2: begin
        lk_r  <= hq_key;
        li_r  <= hq_item;
        rin_r <= (child_r <= {1'b0, size_r});
      end
      OP_SD_CMP: begin
        if (ck_r > ch_key) cur_r <= ch_idx;
      end
      default: ;
    endcase
  end

  // result register, parts the block from a stalled receiver
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.op == OP_DONE && (!out_valid_r || out_ready)) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_DONE && (!out_valid_r || out_ready)) begin
      out_min_key_r  <= KEY_W'(min_key_r);
      out_min_item_r <= ITEM_W'(min_item_r);
      out_status_r   <= status_r;
      out_count_r    <= COUNT_W'(size_r);
    end
  end

  assign out_valid    = out_valid_r;
  assign out_min_key  = out_min_key_r;
  assign out_min_item = out_min_item_r;
  assign out_status   = out_status_r;
  assign out_count    = out_count_r;

  // checks
  a_size_bound: assert property (@(posedge clk) disable iff (!rst_n)
    size_r <= SW'(NUM_ITEMS))
    else $error("heap size beyond capacity");

  a_load_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(cmd.op == OP_DONE))
    else $error("result loaded outside the done step");

  a_up_moves_up: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_SU_CMP && ck_r < hq_key) |=> cur_r < $past(cur_r))
    else $error("sift-up did not move toward the root");

  a_down_moves_down: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_SD_CMP && ck_r > ch_key) |=> cur_r > $past(cur_r))
    else $error("sift-down did not move toward the leaves");

endmodule

`default_nettype wire

/* hdl/indexed_min_heap_decrease_key_unit.sv */
// Indexed binary min-heap with decrease-key, for Prim-style priority queues.
// Input channel in_ch: func (insert/decrease, delete minimum, clear), key, item_id.
// Result channel out_ch: one transaction per input transaction with min_key,
// min_item, status and the heap count after the step.
// Items are handled one at a time; the next is taken only from the idle state.
// Steps from acceptance to a valid result: an unused code goes straight to it;
// insert reads the position entry, checks it, then sifts up; decrease compares
// the keys, then sifts up; delete-min checks for an empty heap, reads the top and
// the last slot, then sifts down unless the heap held one item. Each level of
// sift-up or sift-down reads the heap memory once per compared slot, then compares.
// Clear sweeps all NUM_ITEMS entries of the position table one entry per cycle,
// then returns its result. After reset the same sweep runs with in_ready low
// and no result. A finished result waits in an output register; while the
// receiver stalls, the next input transaction is still taken and worked on up
// to its own result.
// Depends on idkh_pkg, idkh_in_if, idkh_out_if, idkh_ctrl and idkh_dp.
`default_nettype none

module indexed_min_heap_decrease_key_unit
  import idkh_pkg::*;
#(
  parameter int unsigned NUM_ITEMS = 1024,
  parameter int unsigned KEY_BITS  = 32
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  idkh_in_if.sink    in_ch,
  idkh_out_if.source out_ch
);

  localparam int unsigned IW = (NUM_ITEMS > 1) ? $clog2(NUM_ITEMS) : 1;
  localparam int unsigned SW = $clog2(NUM_ITEMS + 1);

  cmd_t     cmd;
  dp_stat_t stat;
  logic     in_ready;

  assign in_ch.ready = in_ready;

  // sequencer
  idkh_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_func  (in_ch.func),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // heap storage and result register
  idkh_dp #(
    .NUM_ITEMS (NUM_ITEMS),
    .KEY_BITS  (KEY_BITS),
    .IW        (IW),
    .SW        (SW)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .stat         (stat),
    .in_key       (in_ch.key),
    .in_item_id   (in_ch.item_id),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .out_min_key  (out_ch.min_key),
    .out_min_item (out_ch.min_item),
    .out_status   (out_ch.status),
    .out_count    (out_ch.count)
  );

endmodule

`default_nettype wire

/* tb/indexed_min_heap_decrease_key_unit_test.sv */
// testbench for the indexed min-heap decrease-key unit: directed table, random, full heap
// depends on idkh_pkg, idkh_in_if, idkh_out_if and indexed_min_heap_decrease_key_unit
`default_nettype none

module indexed_min_heap_decrease_key_unit_test;
  import idkh_pkg::*;

  localparam int NITEMS = 1024;

  typedef struct packed {
    logic [KEY_W-1:0]    min_key;
    logic [ITEM_W-1:0]   min_item;
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  count;
  } heap_res_t;

  typedef struct {
    logic [FUNC_W-1:0] func;
    logic [KEY_W-1:0]  key;
    logic [ITEM_W-1:0] item_id;
    bit                has_exp;
    heap_res_t         exp;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  idkh_in_if  in_ch ();
  idkh_out_if out_ch ();

  indexed_min_heap_decrease_key_unit uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // predictor copy of the heap
  logic [KEY_W-1:0]   hk [1:NITEMS];
  logic [ITEM_W-1:0]  hi [1:NITEMS];
  int unsigned        ipos [NITEMS];
  bit                 ipv [NITEMS];
  bit                 irm [NITEMS];
  int unsigned        hsize;

  heap_res_t result_q[$];
  int errors = 0;
  int n_results = 0;
  int n_removed = 0;
  int n_decreased = 0;
  bit no_idle = 1'b0;
  bit hold_long = 1'b0;

  function automatic void heap_clear();
    for (int i = 0; i < NITEMS; i++) begin
      ipv[i] = 1'b0;
      irm[i] = 1'b0;
    end
    hsize = 0;
  endfunction

  function automatic void slot_swap(int unsigned a, int unsigned b);
    logic [KEY_W-1:0] tk;
    logic [ITEM_W-1:0] ti;
    tk = hk[a]; ti = hi[a];
    hk[a] = hk[b]; hi[a] = hi[b];
    hk[b] = tk; hi[b] = ti;
    ipos[hi[a]] = a;
    ipos[hi[b]] = b;
  endfunction

  function automatic void heap_up(int unsigned p);
    while (p > 1 && hk[p] < hk[p/2]) begin
      slot_swap(p, p/2);
      p = p / 2;
    end
  endfunction

  function automatic void heap_down(int unsigned p);
    int unsigned c;
    forever begin
      c = 2 * p;
      if (c > hsize) break;
      if (c + 1 <= hsize && hk[c+1] < hk[c]) c++;
      if (!(hk[p] > hk[c])) break;
      slot_swap(p, c);
      p = c;
    end
  endfunction

  // compute the expected result of one request and advance the heap copy
  function automatic heap_res_t heap_predict(logic [1:0] fn, logic [31:0] k, logic [9:0] id);
    heap_res_t r;
    int unsigned p;
    int unsigned top;
    r = '0;
    r.status = ST_IGNORED;
    if (fn == FN_INSERT) begin
      if (!irm[id]) begin
        if (ipv[id]) begin
          p = ipos[id];
          if (k < hk[p]) begin
            hk[p] = k;
            heap_up(p);
            r.status = ST_DECREASED;
          end
        end else if (hsize < NITEMS) begin
          hsize++;
          hk[hsize] = k;
          hi[hsize] = id;
          ipos[id] = hsize;
          ipv[id] = 1'b1;
          heap_up(hsize);
          r.status = ST_INSERTED;
        end
      end
    end else if (fn == FN_DELMIN) begin
      if (hsize == 0) begin
        r.status = ST_EMPTY;
      end else begin
        top = hi[1];
        r.min_key = hk[1];
        r.min_item = ITEM_W'(top);
        irm[top] = 1'b1;
        ipv[top] = 1'b0;
        if (hsize > 1) begin
          hk[1] = hk[hsize];
          hi[1] = hi[hsize];
          ipos[hi[1]] = 1;
        end
        hsize--;
        heap_down(1);
        r.status = ST_REMOVED;
      end
    end else if (fn == FN_CLEAR) begin
      heap_clear();
      r.status = ST_EMPTY;
    end
    r.count = COUNT_W'(hsize);
    return r;
  endfunction

  // clock
  initial begin
    forever #6 clk = ~clk;
  end

  // watchdog
  initial begin
    #60000000;
    $display("Verification failed");
    $finish;
  end

  // receiver side with random stalls and one long hold-off
  initial begin
    int gap;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_long) begin
        out_ch.ready <= 1'b0;
        repeat (200) @(posedge clk);
        hold_long = 1'b0;
      end
      if (!no_idle && $urandom_range(0, 5) == 0) begin
        gap = $urandom_range(1, 3);
        out_ch.ready <= 1'b0;
        repeat (gap - 1) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    heap_res_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      n_results++;
      if (result_q.size() == 0) begin
        $error("result transaction with nothing expected");
        errors++;
      end else begin
        e = result_q.pop_front();
        if (out_ch.min_key !== e.min_key) begin
          $error("min_key expected %0h actual %0h", e.min_key, out_ch.min_key); errors++;
        end
        if (out_ch.min_item !== e.min_item) begin
          $error("min_item expected %0d actual %0d", e.min_item, out_ch.min_item); errors++;
        end
        if (out_ch.status !== e.status) begin
          $error("status expected %0d actual %0d", e.status, out_ch.status); errors++;
        end
        if (out_ch.count !== e.count) begin
          $error("count expected %0d actual %0d", e.count, out_ch.count); errors++;
        end
        if (e.status == ST_REMOVED) n_removed++;
        if (e.status == ST_DECREASED) n_decreased++;
      end
    end
  end

  // send one request; the prediction is queued at acceptance
  task automatic send_req(logic [1:0] fn, logic [31:0] k, logic [9:0] id,
                          bit has_exp, heap_res_t fixed);
    heap_res_t p;
    int gap;
    if (!no_idle && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 3);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.func    <= fn;
    in_ch.key     <= k;
    in_ch.item_id <= id;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    p = heap_predict(fn, k, id);
    if (has_exp && p != fixed) begin
      $error("directed row expected %0h but predictor gives %0h", fixed, p);
      errors++;
    end
    result_q.push_back(p);
  endtask

  function automatic heap_res_t mk(logic [31:0] k, logic [9:0] it, logic [2:0] st,
                                   logic [10:0] c);
    heap_res_t r;
    r.min_key = k; r.min_item = it; r.status = st; r.count = c;
    return r;
  endfunction

  // stimulus
  initial begin
    dir_row_t rows[$];
    logic [1:0] fn;
    logic [31:0] k;
    logic [9:0] id;
    int r;
    int wait_c;
    heap_res_t z;
    z = '0;
    in_ch.valid = 1'b0;
    in_ch.func = FN_INSERT;
    in_ch.key = '0;
    in_ch.item_id = '0;
    heap_clear();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed table: empty, extremes, decrease, ties, removed, unused code, clear
    rows.push_back('{FN_DELMIN, 32'h0, 10'd0, 1, mk(0, 0, ST_EMPTY, 0)});
    rows.push_back('{FN_INSERT, 32'hFFFFFFFF, 10'd1023, 1, mk(0, 0, ST_INSERTED, 1)});
    rows.push_back('{FN_INSERT, 32'h0, 10'd0, 1, mk(0, 0, ST_INSERTED, 2)});
    rows.push_back('{FN_INSERT, 32'h5, 10'd7, 1, mk(0, 0, ST_INSERTED, 3)});
    rows.push_back('{FN_INSERT, 32'h5, 10'd8, 1, mk(0, 0, ST_INSERTED, 4)});
    rows.push_back('{FN_INSERT, 32'h5, 10'd9, 1, mk(0, 0, ST_INSERTED, 5)});
    rows.push_back('{FN_INSERT, 32'h6, 10'd7, 1, mk(0, 0, ST_IGNORED, 5)});
    rows.push_back('{FN_INSERT, 32'h5, 10'd7, 1, mk(0, 0, ST_IGNORED, 5)});
    rows.push_back('{FN_INSERT, 32'h1, 10'd1023, 1, mk(0, 0, ST_DECREASED, 5)});
    rows.push_back('{2'd3, 32'hAAAA5555, 10'd512, 1, mk(0, 0, ST_IGNORED, 5)});
    rows.push_back('{FN_DELMIN, 32'h0, 10'd0, 1, mk(0, 0, ST_REMOVED, 4)});
    rows.push_back('{FN_INSERT, 32'h3, 10'd0, 1, mk(0, 0, ST_IGNORED, 4)});
    rows.push_back('{FN_DELMIN, 32'h0, 10'd0, 1, mk(1, 1023, ST_REMOVED, 3)});
    rows.push_back('{FN_DELMIN, 32'h0, 10'd0, 0, z});
    rows.push_back('{FN_DELMIN, 32'h0, 10'd0, 0, z});
    rows.push_back('{FN_INSERT, 32'h2, 10'd9, 0, z});
    rows.push_back('{FN_DELMIN, 32'h0, 10'd0, 0, z});
    rows.push_back('{FN_DELMIN, 32'h0, 10'd0, 1, mk(0, 0, ST_EMPTY, 0)});
    rows.push_back('{FN_INSERT, 32'h10, 10'd300, 1, mk(0, 0, ST_INSERTED, 1)});
    rows.push_back('{FN_CLEAR, 32'h0, 10'd0, 1, mk(0, 0, ST_EMPTY, 0)});
    rows.push_back('{FN_INSERT, 32'h1, 10'd0, 1, mk(0, 0, ST_INSERTED, 1)});
    rows.push_back('{FN_DELMIN, 32'h0, 10'd0, 1, mk(1, 0, ST_REMOVED, 0)});
    foreach (rows[i])
      send_req(rows[i].func, rows[i].key, rows[i].item_id, rows[i].has_exp, rows[i].exp);

    // random: mostly inserts and decreases on small id and key pools, some delete-min
    for (int n = 0; n < 860; n++) begin
      if (n == 300) hold_long = 1'b1;
      if (n == 700) no_idle = 1'b1;
      r = $urandom_range(0, 99);
      k = $urandom;
      id = ITEM_W'($urandom);
      if (r < 2) begin
        fn = FN_CLEAR;
      end else if (r < 4) begin
        fn = 2'd3;
      end else if (r < 35) begin
        fn = FN_DELMIN;
      end else begin
        fn = FN_INSERT;
        if ($urandom_range(0, 2) != 0) id = ITEM_W'($urandom_range(0, 63));
        if ($urandom_range(0, 1) == 0) k = $urandom_range(0, 15);
      end
      send_req(fn, k, id, 0, z);
    end

    // fill to the top so the heap reaches full capacity, then drain a bit
    send_req(FN_CLEAR, 32'h0, 10'd0, 0, z);
    for (int n = 0; n < NITEMS; n++)
      send_req(FN_INSERT, $urandom_range(0, 255), n[9:0], 0, z);
    send_req(FN_INSERT, 32'h0, 10'd5, 0, z);
    send_req(FN_DELMIN, 32'h0, 10'd0, 0, z);
    send_req(FN_INSERT, 32'h0, 10'd5, 0, z);
    for (int n = 0; n < 40; n++)
      send_req(FN_DELMIN, 32'h0, 10'd0, 0, z);
    in_ch.valid <= 1'b0;

    wait_c = 0;
    while (result_q.size() != 0 && wait_c < 100000) begin
      @(posedge clk);
      wait_c++;
    end
    repeat (100) @(posedge clk);
    $display("covered %0d results: %0d removed minima, %0d decreased keys, full heap",
             n_results, n_removed, n_decreased);
    if (errors == 0 && result_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* indexed_min_heap_decrease_key_unit.f */
hdl/idkh_pkg.sv
hdl/idkh_in_if.sv
hdl/idkh_out_if.sv
hdl/idkh_ctrl.sv
hdl/idkh_dp.sv
hdl/indexed_min_heap_decrease_key_unit.sv
tb/indexed_min_heap_decrease_key_unit_test.sv
